// ----- rtl/owtp_pkg.sv -----
// Shared types, codes and slot timing tables for the 1-Wire temperature poller.
// No dependencies.
package owtp_pkg;

    localparam int MAX_SENSORS = 3;

    localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
    localparam logic [7:0] CMD_READ_PAD   = 8'hBE;
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] PAD_RESERVED_5 = 8'hFF;
    localparam logic [7:0] PAD_RESERVED_7 = 8'h10;
    localparam logic [7:0] PAD_MSB_LIMIT  = 8'h07;
    localparam int         PAD_BYTES      = 9;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_LOW     = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_SAMPLE  = 2'd3
    } bus_act_t;

    typedef enum logic [2:0] {
        TBL_NONE   = 3'd0,
        TBL_RESET  = 3'd1,
        TBL_READ   = 3'd2,
        TBL_WRITE0 = 3'd3,
        TBL_WRITE1 = 3'd4
    } slot_tbl_t;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } byte_mode_t;

    typedef enum logic [3:0] {
        PH_BUS_RESET  = 4'd0,
        PH_MATCH_ROM  = 4'd1,
        PH_ROM_BYTES  = 4'd2,
        PH_READ_CMD   = 4'd3,
        PH_READ_START = 4'd4,
        PH_READ_BYTES = 4'd5,
        PH_SKIP_ROM   = 4'd7,
        PH_CONVERT    = 4'd8,
        PH_LONG_WAIT  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        REG_SENSOR_COUNT = 2'd0,
        REG_ROM_FIRST    = 2'd1,
        REG_ROM_SECOND   = 2'd2,
        REG_ROM_THIRD    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        bus_act_t    act;
        logic [11:0] dly;
    } slot_entry_t;

    function automatic slot_entry_t mk_entry(bus_act_t act, logic [11:0] dly);
        slot_entry_t e;
        e.act = act;
        e.dly = dly;
        return e;
    endfunction

    // Slot timing tables; an entry with zero delay ends the slot.
    function automatic slot_entry_t slot_lookup(slot_tbl_t tbl, logic [2:0] idx);
        slot_entry_t e;
        e = mk_entry(ACT_NONE, 12'd0);
        case (tbl)
            TBL_RESET:
            begin
                case (idx)
                    3'd0:    e = mk_entry(ACT_NONE, 12'd1);
                    3'd1:    e = mk_entry(ACT_LOW, 12'd480);
                    3'd2:    e = mk_entry(ACT_RELEASE, 12'd70);
                    3'd3:    e = mk_entry(ACT_SAMPLE, 12'd410);
                    default: e = mk_entry(ACT_NONE, 12'd0);
                endcase
            end
            TBL_READ:
            begin
                case (idx)
                    3'd0:    e = mk_entry(ACT_LOW, 12'd6);
                    3'd1:    e = mk_entry(ACT_RELEASE, 12'd7);
                    3'd2:    e = mk_entry(ACT_SAMPLE, 12'd55);
                    default: e = mk_entry(ACT_NONE, 12'd0);
                endcase
            end
            TBL_WRITE0:
            begin
                case (idx)
                    3'd0:    e = mk_entry(ACT_LOW, 12'd60);
                    3'd1:    e = mk_entry(ACT_RELEASE, 12'd10);
                    3'd2:    e = mk_entry(ACT_SAMPLE, 12'd0);
                    default: e = mk_entry(ACT_NONE, 12'd0);
                endcase
            end
            TBL_WRITE1:
            begin
                case (idx)
                    3'd0:    e = mk_entry(ACT_LOW, 12'd6);
                    3'd1:    e = mk_entry(ACT_RELEASE, 12'd64);
                    3'd2:    e = mk_entry(ACT_SAMPLE, 12'd0);
                    default: e = mk_entry(ACT_NONE, 12'd0);
                endcase
            end
            default: e = mk_entry(ACT_NONE, 12'd0);
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/one_wire_temperature_poller_top.sv -----
// 1-Wire temperature poller: slot sequencer, byte layer and phase machine.
// Depends on owtp_pkg (rtl/owtp_pkg.sv).
//
// An accepted timer event has its result in the output register in the next cycle.
// Throughput: one event per clock; the next event is taken while a result waits,
// as long as the output register is free or is being emptied in the same cycle.
// Reset (rst_n low, asynchronous): bus sequencer restarts at a bus reset slot, phase 0,
// sensor count and ROM codes clear, output register empties. No clearing pass.
module one_wire_temperature_poller_top (
    input  logic        clk,
    input  logic        rst_n,
    // timer event requests
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        line_level,
    // result requests
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  bus_action,
    output logic [11:0] delay_us,
    output logic        temp_valid,
    output logic [1:0]  temp_sensor,
    output logic [15:0] temp_value,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import owtp_pkg::*;

    // Configuration registers
    logic [1:0]  sensor_count_reg;
    logic [63:0] rom_first_reg;
    logic [63:0] rom_second_reg;
    logic [63:0] rom_third_reg;

    // Sequencer state
    slot_tbl_t   slot_table_reg,    slot_table_next;
    logic [2:0]  slot_index_reg,    slot_index_next;
    logic        last_sample_reg,   last_sample_next;
    logic [3:0]  bit_counter_reg,   bit_counter_next;
    logic [7:0]  shift_byte_reg,    shift_byte_next;
    byte_mode_t  byte_mode_reg,     byte_mode_next;
    logic [1:0]  sensor_index_reg,  sensor_index_next;
    logic [3:0]  rom_byte_idx_reg,  rom_byte_idx_next;
    logic [3:0]  scratch_index_reg, scratch_index_next;
    phase_t      phase_reg,         phase_next;

    // Only the scratchpad bytes that feed the check and the result are kept
    logic [7:0]  pad_b0_reg, pad_b0_next;
    logic [7:0]  pad_b1_reg, pad_b1_next;
    logic [7:0]  pad_b5_reg, pad_b5_next;
    logic [7:0]  pad_b7_reg, pad_b7_next;

    // Output register
    logic        out_valid_reg;
    bus_act_t    act_reg,      act_next;
    logic [11:0] dly_reg,      dly_next;
    logic        tvalid_reg,   tvalid_next;
    logic [1:0]  tsensor_reg,  tsensor_next;
    logic [15:0] tvalue_reg,   tvalue_next;

    logic        in_accept;
    logic        cfg_write;
    slot_entry_t entry;
    logic [1:0]  limit;
    logic [63:0] rom_sel;
    logic [1:0]  sensor_mod;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Clamp sensor count to the number of ROM slots
    assign limit = (32'(sensor_count_reg) > MAX_SENSORS) ? 2'(MAX_SENSORS) : sensor_count_reg;

    // Sensor index modulo three; index three only arises after the last sensor
    assign sensor_mod = (sensor_index_reg == 2'd3) ? 2'd0 : sensor_index_reg;

    always_comb
    begin
        case (sensor_mod)
            2'd1:    rom_sel = rom_second_reg;
            2'd2:    rom_sel = rom_third_reg;
            default: rom_sel = rom_first_reg;
        endcase
    end

    // Register readback
    always_comb
    begin
        case (reg_idx_t'(paddr[4:3]))
            REG_SENSOR_COUNT: prdata = {62'd0, sensor_count_reg};
            REG_ROM_FIRST:    prdata = rom_first_reg;
            REG_ROM_SECOND:   prdata = rom_second_reg;
            REG_ROM_THIRD:    prdata = rom_third_reg;
            default:          prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= 2'd0;
            rom_first_reg    <= 64'd0;
            rom_second_reg   <= 64'd0;
            rom_third_reg    <= 64'd0;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[4:3]))
                REG_SENSOR_COUNT: sensor_count_reg <= pwdata[1:0];
                REG_ROM_FIRST:    rom_first_reg    <= pwdata;
                REG_ROM_SECOND:   rom_second_reg   <= pwdata;
                REG_ROM_THIRD:    rom_third_reg    <= pwdata;
                default:          ;
            endcase
        end
    end

    // One event: apply the current slot entry, step the byte layer, then the
    // phase machine when the byte layer has run dry.
    always_comb
    begin
        entry = slot_lookup(slot_table_reg, slot_index_reg);

        slot_table_next    = slot_table_reg;
        last_sample_next   = last_sample_reg;
        bit_counter_next   = bit_counter_reg;
        shift_byte_next    = shift_byte_reg;
        byte_mode_next     = byte_mode_reg;
        sensor_index_next  = sensor_index_reg;
        rom_byte_idx_next  = rom_byte_idx_reg;
        scratch_index_next = scratch_index_reg;
        phase_next         = phase_reg;
        pad_b0_next        = pad_b0_reg;
        pad_b1_next        = pad_b1_reg;
        pad_b5_next        = pad_b5_reg;
        pad_b7_next        = pad_b7_reg;

        act_next     = entry.act;
        dly_next     = entry.dly;
        tvalid_next  = 1'b0;
        tsensor_next = 2'd0;
        tvalue_next  = 16'd0;

        slot_index_next = slot_index_reg + 3'd1;
        if (entry.act == ACT_SAMPLE)
        begin
            last_sample_next = line_level;
        end

        // End of slot: hand over to the byte layer
        if (entry.dly == 12'd0)
        begin
            dly_next        = 12'd1;
            slot_index_next = 3'd0;
            case (byte_mode_reg)
                MODE_READ:
                begin
                    bit_counter_next = bit_counter_reg + 4'd1;
                    if (last_sample_next)
                    begin
                        shift_byte_next = shift_byte_reg | 8'h80;
                    end
                    if (bit_counter_next > 4'd7)
                    begin
                        slot_table_next = TBL_NONE;
                    end
                    else
                    begin
                        shift_byte_next = shift_byte_next >> 1;
                    end
                end
                MODE_WRITE:
                begin
                    slot_table_next  = shift_byte_reg[0] ? TBL_WRITE1 : TBL_WRITE0;
                    shift_byte_next  = shift_byte_reg >> 1;
                    bit_counter_next = bit_counter_reg + 4'd1;
                    if (bit_counter_next > 4'd8)
                    begin
                        slot_table_next = TBL_NONE;
                    end
                end
                default: slot_table_next = TBL_NONE;
            endcase
        end

        // Byte layer idle: advance the transaction
        if (slot_table_next == TBL_NONE)
        begin
            bit_counter_next = 4'd0;
            dly_next         = 12'd1;
            case (phase_reg)
                PH_BUS_RESET:
                begin
                    byte_mode_next  = MODE_RESET;
                    slot_table_next = TBL_RESET;
                    if (sensor_index_reg >= limit)
                    begin
                        sensor_index_next = 2'd0;
                        phase_next        = PH_SKIP_ROM;
                    end
                    else
                    begin
                        phase_next = PH_MATCH_ROM;
                    end
                end
                PH_MATCH_ROM:
                begin
                    // No presence pulse: drop the sensor round and wait long
                    if (last_sample_next)
                    begin
                        phase_next = PH_BUS_RESET;
                        dly_next   = 12'd0;
                    end
                    else
                    begin
                        byte_mode_next  = MODE_WRITE;
                        shift_byte_next = CMD_MATCH_ROM;
                        phase_next      = PH_ROM_BYTES;
                    end
                end
                PH_ROM_BYTES:
                begin
                    byte_mode_next    = MODE_WRITE;
                    shift_byte_next   = rom_sel[{rom_byte_idx_reg[2:0], 3'd0} +: 8];
                    rom_byte_idx_next = rom_byte_idx_reg + 4'd1;
                    if (rom_byte_idx_next > 4'd7)
                    begin
                        rom_byte_idx_next = 4'd0;
                        phase_next        = PH_READ_CMD;
                    end
                end
                PH_READ_CMD:
                begin
                    byte_mode_next  = MODE_WRITE;
                    shift_byte_next = CMD_READ_PAD;
                    phase_next      = PH_READ_START;
                end
                PH_READ_START:
                begin
                    slot_table_next = TBL_READ;
                    byte_mode_next  = MODE_READ;
                    shift_byte_next = 8'd0;
                    phase_next      = PH_READ_BYTES;
                end
                PH_READ_BYTES:
                begin
                    case (scratch_index_reg)
                        4'd0:    pad_b0_next = shift_byte_next;
                        4'd1:    pad_b1_next = shift_byte_next;
                        4'd5:    pad_b5_next = shift_byte_next;
                        4'd7:    pad_b7_next = shift_byte_next;
                        default: ;
                    endcase
                    scratch_index_next = scratch_index_reg + 4'd1;
                    if (32'(scratch_index_next) < PAD_BYTES)
                    begin
                        slot_table_next = TBL_READ;
                        byte_mode_next  = MODE_READ;
                        shift_byte_next = 8'd0;
                    end
                    else
                    begin
                        // Last byte read: check reserved bytes and the MSB range
                        if (pad_b5_reg == PAD_RESERVED_5 && pad_b7_reg == PAD_RESERVED_7 &&
                            pad_b1_reg < PAD_MSB_LIMIT)
                        begin
                            tvalid_next  = 1'b1;
                            tsensor_next = sensor_mod;
                            tvalue_next  = {pad_b1_reg, pad_b0_reg};
                        end
                        scratch_index_next = 4'd0;
                        sensor_index_next  = sensor_index_reg + 2'd1;
                        phase_next         = PH_BUS_RESET;
                    end
                end
                PH_SKIP_ROM:
                begin
                    byte_mode_next  = MODE_WRITE;
                    shift_byte_next = CMD_SKIP_ROM;
                    phase_next      = PH_CONVERT;
                end
                PH_CONVERT:
                begin
                    byte_mode_next  = MODE_WRITE;
                    shift_byte_next = CMD_CONVERT;
                    phase_next      = PH_LONG_WAIT;
                end
                PH_LONG_WAIT:
                begin
                    byte_mode_next = MODE_RESET;
                    dly_next       = 12'd0;
                    phase_next     = PH_BUS_RESET;
                end
                default: ;
            endcase
        end
    end

    // Sequencer state advances on each accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_table_reg    <= TBL_RESET;
            slot_index_reg    <= 3'd0;
            last_sample_reg   <= 1'b0;
            bit_counter_reg   <= 4'd0;
            shift_byte_reg    <= 8'd0;
            byte_mode_reg     <= MODE_RESET;
            sensor_index_reg  <= 2'd0;
            rom_byte_idx_reg  <= 4'd0;
            scratch_index_reg <= 4'd0;
            phase_reg         <= PH_BUS_RESET;
        end
        else if (in_accept)
        begin
            slot_table_reg    <= slot_table_next;
            slot_index_reg    <= slot_index_next;
            last_sample_reg   <= last_sample_next;
            bit_counter_reg   <= bit_counter_next;
            shift_byte_reg    <= shift_byte_next;
            byte_mode_reg     <= byte_mode_next;
            sensor_index_reg  <= sensor_index_next;
            rom_byte_idx_reg  <= rom_byte_idx_next;
            scratch_index_reg <= scratch_index_next;
            phase_reg         <= phase_next;
        end
    end

    // Scratchpad bytes and result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pad_b0_reg  <= pad_b0_next;
            pad_b1_reg  <= pad_b1_next;
            pad_b5_reg  <= pad_b5_next;
            pad_b7_reg  <= pad_b7_next;
            act_reg     <= act_next;
            dly_reg     <= dly_next;
            tvalid_reg  <= tvalid_next;
            tsensor_reg <= tsensor_next;
            tvalue_reg  <= tvalue_next;
        end
    end

    // Hold the result until it is taken; refill in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bus_action  = act_reg;
    assign delay_us    = dly_reg;
    assign temp_valid  = tvalid_reg;
    assign temp_sensor = tsensor_reg;
    assign temp_value  = tvalue_reg;

endmodule

// ----- tb/sv/one_wire_poll_checker.sv -----
// Result checker for the 1-Wire temperature poller: tracks timer event requests,
// predicts each result request and compares it field by field.
// Depends on owtp_pkg (rtl/owtp_pkg.sv).
`timescale 1ns / 100ps

module one_wire_poll_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 line_level,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           bus_action,
    input  logic [11:0]          delay_us,
    input  logic                 temp_valid,
    input  logic [1:0]           temp_sensor,
    input  logic [15:0]          temp_value,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending,
    output int                   stored_count,
    output owtp_pkg::byte_mode_t bus_mode,
    output logic [3:0]           read_byte,
    output logic [3:0]           read_bit
);
    import owtp_pkg::*;

    typedef struct packed {
        logic [1:0]  act;
        logic [11:0] wait_us;
        logic        stored;
        logic [1:0]  sensor;
        logic [15:0] reading;
    } poll_result_t;

    // configuration copy
    logic [1:0]  sensor_count;
    logic [63:0] rom_code [3];

    // poller state
    slot_tbl_t   slot_tbl;
    logic [2:0]  slot_pos;
    logic        last_level;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    byte_mode_t  mode;
    logic [1:0]  sensor_idx;
    logic [3:0]  rom_byte;
    logic [3:0]  pad_pos;
    phase_t      phase;
    logic [7:0]  pad [PAD_BYTES];

    poll_result_t expected_results [$];
    poll_result_t want;
    int           fails;
    int           stored;

    // action in bits 13:12, microseconds in bits 11:0
    function automatic logic [13:0] slot_timing(slot_tbl_t tbl, logic [2:0] pos);
        case (tbl)
            TBL_RESET:
            begin
                case (pos)
                    3'd0:    return {ACT_NONE, 12'd1};
                    3'd1:    return {ACT_LOW, 12'd480};
                    3'd2:    return {ACT_RELEASE, 12'd70};
                    3'd3:    return {ACT_SAMPLE, 12'd410};
                    default: return {ACT_NONE, 12'd0};
                endcase
            end
            TBL_READ:
            begin
                case (pos)
                    3'd0:    return {ACT_LOW, 12'd6};
                    3'd1:    return {ACT_RELEASE, 12'd7};
                    3'd2:    return {ACT_SAMPLE, 12'd55};
                    default: return {ACT_NONE, 12'd0};
                endcase
            end
            TBL_WRITE0:
            begin
                case (pos)
                    3'd0:    return {ACT_LOW, 12'd60};
                    3'd1:    return {ACT_RELEASE, 12'd10};
                    3'd2:    return {ACT_SAMPLE, 12'd0};
                    default: return {ACT_NONE, 12'd0};
                endcase
            end
            TBL_WRITE1:
            begin
                case (pos)
                    3'd0:    return {ACT_LOW, 12'd6};
                    3'd1:    return {ACT_RELEASE, 12'd64};
                    3'd2:    return {ACT_SAMPLE, 12'd0};
                    default: return {ACT_NONE, 12'd0};
                endcase
            end
            default: return {ACT_NONE, 12'd0};
        endcase
    endfunction

    // Advance the poller by one timer event and return the result it gives.
    function automatic poll_result_t step_poller(logic lvl);
        poll_result_t r;
        logic [1:0]   act_bits;
        logic [11:0]  us;
        logic [1:0]   lim;
        logic [1:0]   unit;
        r = '0;
        {act_bits, us} = slot_timing(slot_tbl, slot_pos);
        slot_pos = slot_pos + 3'd1;
        if (act_bits == ACT_SAMPLE)
            last_level = lvl;

        // zero delay closes the slot: hand the bit to the byte layer
        if (us == 12'd0)
        begin
            us = 12'd1;
            slot_pos = 3'd0;
            case (mode)
                MODE_READ:
                begin
                    if (last_level)
                        shreg[7] = 1'b1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt > 4'd7)
                        slot_tbl = TBL_NONE;
                    else
                        shreg = shreg >> 1;
                end
                MODE_WRITE:
                begin
                    slot_tbl = shreg[0] ? TBL_WRITE1 : TBL_WRITE0;
                    shreg = shreg >> 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt > 4'd8)
                        slot_tbl = TBL_NONE;
                end
                default: slot_tbl = TBL_NONE;
            endcase
        end

        if (slot_tbl == TBL_NONE)
        begin
            bit_cnt = 4'd0;
            us = 12'd1;
            lim = (sensor_count > MAX_SENSORS) ? 2'(MAX_SENSORS) : sensor_count;
            unit = (sensor_idx == 2'd3) ? 2'd0 : sensor_idx;
            case (phase)
                PH_BUS_RESET:
                begin
                    mode = MODE_RESET;
                    slot_tbl = TBL_RESET;
                    if (sensor_idx >= lim)
                    begin
                        sensor_idx = 2'd0;
                        phase = PH_SKIP_ROM;
                    end
                    else
                        phase = PH_MATCH_ROM;
                end
                PH_MATCH_ROM:
                begin
                    // line still high after the reset: nobody answered
                    if (last_level)
                    begin
                        phase = PH_BUS_RESET;
                        us = 12'd0;
                    end
                    else
                    begin
                        mode = MODE_WRITE;
                        shreg = CMD_MATCH_ROM;
                        phase = PH_ROM_BYTES;
                    end
                end
                PH_ROM_BYTES:
                begin
                    mode = MODE_WRITE;
                    shreg = 8'(rom_code[unit] >> {rom_byte[2:0], 3'b000});
                    rom_byte = rom_byte + 4'd1;
                    if (rom_byte > 4'd7)
                    begin
                        rom_byte = 4'd0;
                        phase = PH_READ_CMD;
                    end
                end
                PH_READ_CMD:
                begin
                    mode = MODE_WRITE;
                    shreg = CMD_READ_PAD;
                    phase = PH_READ_START;
                end
                PH_READ_START:
                begin
                    slot_tbl = TBL_READ;
                    mode = MODE_READ;
                    shreg = 8'd0;
                    phase = PH_READ_BYTES;
                end
                PH_READ_BYTES:
                begin
                    if (pad_pos < PAD_BYTES)
                        pad[pad_pos] = shreg;
                    pad_pos = pad_pos + 4'd1;
                    if (pad_pos < PAD_BYTES)
                    begin
                        slot_tbl = TBL_READ;
                        mode = MODE_READ;
                        shreg = 8'd0;
                    end
                    else
                    begin
                        if (pad[5] == PAD_RESERVED_5 && pad[7] == PAD_RESERVED_7 &&
                            pad[1] < PAD_MSB_LIMIT)
                        begin
                            r.stored = 1'b1;
                            r.sensor = unit;
                            r.reading = {pad[1], pad[0]};
                        end
                        pad_pos = 4'd0;
                        sensor_idx = sensor_idx + 2'd1;
                        phase = PH_BUS_RESET;
                    end
                end
                PH_SKIP_ROM:
                begin
                    mode = MODE_WRITE;
                    shreg = CMD_SKIP_ROM;
                    phase = PH_CONVERT;
                end
                PH_CONVERT:
                begin
                    mode = MODE_WRITE;
                    shreg = CMD_CONVERT;
                    phase = PH_LONG_WAIT;
                end
                PH_LONG_WAIT:
                begin
                    mode = MODE_RESET;
                    us = 12'd0;
                    phase = PH_BUS_RESET;
                end
                default: ;
            endcase
        end
        r.act = act_bits;
        r.wait_us = us;
        return r;
    endfunction

    function automatic void check_field(string field, logic [15:0] exp_v, logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count = 2'd0;
            foreach (rom_code[i])
                rom_code[i] = 64'd0;
            slot_tbl = TBL_RESET;
            slot_pos = 3'd0;
            last_level = 1'b0;
            bit_cnt = 4'd0;
            shreg = 8'd0;
            mode = MODE_RESET;
            sensor_idx = 2'd0;
            rom_byte = 4'd0;
            pad_pos = 4'd0;
            phase = PH_BUS_RESET;
            foreach (pad[i])
                pad[i] = 8'd0;
            expected_results.delete();
            fails = 0;
            stored = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:3]))
                    REG_SENSOR_COUNT: sensor_count = pwdata[1:0];
                    REG_ROM_FIRST:    rom_code[0] = pwdata;
                    REG_ROM_SECOND:   rom_code[1] = pwdata;
                    REG_ROM_THIRD:    rom_code[2] = pwdata;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                expected_results.push_back(step_poller(line_level));

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result request arrived with no timer event outstanding");
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("bus_action", 16'(want.act), 16'(bus_action));
                    check_field("delay_us", 16'(want.wait_us), 16'(delay_us));
                    check_field("temp_valid", 16'(want.stored), 16'(temp_valid));
                    check_field("temp_sensor", 16'(want.sensor), 16'(temp_sensor));
                    check_field("temp_value", want.reading, temp_value);
                    if (want.stored)
                        stored++;
                end
            end
        end

        // publish after the edge so the stimulus side never races the update
        fail_count <= fails;
        pending <= expected_results.size();
        stored_count <= stored;
        bus_mode <= mode;
        read_byte <= pad_pos;
        read_bit <= bit_cnt;
    end

endmodule

// ----- tb/sv/one_wire_temperature_poller_top_test.sv -----
// Top level of the 1-Wire temperature poller testbench: clock, reset, register
// writes, timer event stimulus with a simple sensor on the line, and the verdict.
// Depends on owtp_pkg, one_wire_temperature_poller_top and one_wire_poll_checker.
`timescale 1ns / 100ps

module one_wire_temperature_poller_top_test;
    import owtp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        line_level = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  bus_action;
    logic [11:0] delay_us;
    logic        temp_valid;
    logic [1:0]  temp_sensor;
    logic [15:0] temp_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [63:0] pwdata = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          stored_count;
    byte_mode_t  bus_mode;
    logic [3:0]  read_byte;
    logic [3:0]  read_bit;

    // scratchpad the simulated sensor returns, and whether it answers the reset
    logic [7:0]  pad_image [PAD_BYTES];
    logic        sensor_absent = 1'b0;
    logic [7:0]  stall_tick = 8'd0;
    int          events_sent = 0;

    one_wire_temperature_poller_top u_dut (.*);

    one_wire_poll_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls on a rolling pattern: a window always ready, a window with
    // light random stalls, a fixed on/off comb and a window of coin-flip stalls.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_tick[7:6])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= (stall_tick[1:0] != 2'd3);
            default: out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Generous hard stop in case the handshakes never complete.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Choose the line level for the next timer event. The checker's view of the
    // byte layer lags by at most one request, which always stays inside the
    // same slot, so the sample lands on the bit the sensor is meant to return.
    function automatic logic pick_level(bit noisy);
        int k;
        if (noisy)
            return 1'($urandom_range(0, 1));
        case (bus_mode)
            MODE_RESET: return sensor_absent;
            MODE_READ:
            begin
                if (read_byte < PAD_BYTES)
                    return pad_image[read_byte][read_bit[2:0]];
                return 1'b0;
            end
            default:
            begin
                // while commands go out, roll the next sensor answer: mostly a
                // valid scratchpad, sometimes with one of the check bytes broken
                for (k = 0; k < PAD_BYTES; k++)
                    pad_image[k] = 8'($urandom);
                pad_image[1] = 8'($urandom_range(0, 6));
                pad_image[5] = PAD_RESERVED_5;
                pad_image[7] = PAD_RESERVED_7;
                case ($urandom_range(0, 7))
                    0:       pad_image[5] = 8'($urandom_range(0, 254));
                    1:       pad_image[7] = 8'($urandom_range(17, 255));
                    2:       pad_image[1] = 8'($urandom_range(7, 255));
                    default: ;
                endcase
                sensor_absent = ($urandom_range(0, 7) == 0);
                return 1'($urandom_range(0, 1));
            end
        endcase
    endfunction

    // Hold one timer event request on the channel until it is taken.
    task automatic offer_event(logic lvl);
        in_valid <= 1'b1;
        line_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
    endtask

    // Send requests in bursts of random length with random gaps; a third of
    // the bursts run straight into the next one.
    task automatic run_events(int count, bit noisy);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && sent < count)
            begin
                offer_event(pick_level(noisy));
                sent++;
                burst--;
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Let the last request be counted, then wait until every result has come back
    // and the output register has settled.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that closes the access cycle.
    task automatic reg_write(reg_idx_t idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start with no sensors: the poller only resets, skips ROM and converts.
        reg_write(REG_SENSOR_COUNT, 64'd0);
        reg_write(REG_ROM_FIRST, 64'd0);
        reg_write(REG_ROM_SECOND, 64'h0123_4567_89AB_CDEF);
        reg_write(REG_ROM_THIRD, 64'hFEDC_BA98_7654_3210);

        // Short directed run back to back: both line levels, no gaps.
        for (i = 0; i < 25; i++)
            offer_event(logic'(i[0] ^ (i >= 12)));
        in_valid <= 1'b0;
        drain();

        // One sensor with an all-ones ROM; pause once mid-run until the
        // result channel is empty, then carry on.
        reg_write(REG_SENSOR_COUNT, 64'd1);
        reg_write(REG_ROM_FIRST, '1);
        run_events(300, 1'b0);
        drain();
        run_events(300, 1'b0);
        drain();

        // Full sensor count: first ROM all zero, the others random.
        reg_write(REG_SENSOR_COUNT, 64'd3);
        reg_write(REG_ROM_FIRST, 64'd0);
        reg_write(REG_ROM_SECOND, {$urandom, $urandom});
        reg_write(REG_ROM_THIRD, {$urandom, $urandom});
        run_events(450, 1'b0);
        drain();

        // Two sensors with a garbage line: broken presence and junk reads.
        reg_write(REG_SENSOR_COUNT, 64'd2);
        reg_write(REG_ROM_SECOND, '1);
        run_events(150, 1'b1);
        drain();

        // Back to no sensors: several conversion cycles with long waits.
        reg_write(REG_SENSOR_COUNT, 64'd0);
        run_events(150, 1'b0);
        drain();

        $display("Run covered %0d timer events over sensor counts 0 to 3,", events_sent);
        $display("with %0d validated temperatures stored and %0d mismatches.",
                 stored_count, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
